>>> hdl/bgr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bgr_pkg
// Shared types, codes and defaults of the button gesture relay controller.
// ----------------------------------------------------------------------------
package bgr_pkg;

  // default parameter values
  localparam int unsigned RELAY_COUNT_DEF      = 6;
  localparam int unsigned LONG_PRESS_TICKS_DEF = 10;
  localparam int unsigned TICKS_PER_SECOND_DEF = 10;
  localparam int unsigned CLICK_GAP_TICKS_DEF  = 4;
  localparam int unsigned KEY_MAP_ENTRIES_DEF  = 30;

  localparam int unsigned RELAY_W   = 6;
  localparam int unsigned KEY_REG_W = 64;
  localparam int unsigned KEY_REGS  = 4;
  localparam int unsigned CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_TOP  = 2'd3;

  // input modes
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_SOFT = 1'b1;

  // software command values
  localparam logic [1:0] SOCK_OFF    = 2'd0;
  localparam logic [1:0] SOCK_ON     = 2'd1;
  localparam logic [1:0] SOCK_TOGGLE = 2'd2;

  // event kinds
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_CLICK = 2'd1;
  localparam logic [1:0] EV_LONG  = 2'd2;

  // function codes
  localparam logic [3:0] FN_TOGGLE_ALL  = 4'd0;
  localparam logic [3:0] FN_RELAY_FIRST = 4'd1;
  localparam logic [3:0] FN_RELAY_LAST  = 4'd6;
  localparam logic [3:0] FN_LED         = 4'd7;
  localparam logic [3:0] FN_REBOOT      = 4'd8;
  localparam logic [3:0] FN_WIFI        = 4'd9;
  localparam logic [3:0] FN_FACTORY     = 4'd10;
  localparam logic [3:0] FN_LOCK        = 4'd11;
  localparam logic [3:0] FN_NONE        = 4'd15;

  // blink lengths in LED toggles
  localparam logic [4:0] BLINK_WIFI_LIMIT    = 5'd6;
  localparam logic [4:0] BLINK_FACTORY_LIMIT = 5'd16;

  typedef struct packed {
    logic       mode;
    logic       button_pressed;
    logic [2:0] socket_index;
    logic [1:0] socket_value;
  } in_word_t;

  typedef struct packed {
    logic [RELAY_W-1:0] relay_outputs;
    logic               led_on;
    logic               led_enabled;
    logic               child_lock_on;
    logic [1:0]         event_kind;
    logic [7:0]         event_count;
    logic [3:0]         action_code;
    logic               action_blocked;
    logic               reboot_request;
    logic               wifi_setup_request;
    logic               factory_reset_request;
  } out_word_t;

endpackage
`default_nettype wire

>>> hdl/bgr_keymap.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bgr_keymap
// Key map registers, written over the config port, byte lookup by count.
// ----------------------------------------------------------------------------
module bgr_keymap (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [bgr_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [bgr_pkg::KEY_REG_W-1:0]        cfg_data_i,
  input  wire logic [4:0]                           key_index_i,
  output logic      [7:0]                           key_byte_o
);

  logic [bgr_pkg::KEY_REG_W-1:0] key_map_q [bgr_pkg::KEY_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(bgr_pkg::KEY_REGS); i++) begin
        key_map_q[i] <= '1;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bgr_pkg::REG_KEY_LOW:  key_map_q[0] <= cfg_data_i;
        bgr_pkg::REG_KEY_MID:  key_map_q[1] <= cfg_data_i;
        bgr_pkg::REG_KEY_HIGH: key_map_q[2] <= cfg_data_i;
        bgr_pkg::REG_KEY_TOP:  key_map_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // byte n sits in register n>>3, byte lane n&7
  assign key_byte_o = key_map_q[key_index_i[4:3]][{key_index_i[2:0], 3'b000} +: 8];

endmodule
`default_nettype wire

>>> hdl/bgr_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bgr_core
// Gesture tracking, key dispatch, relay/LED/lock state; one word per proc_i.
// ----------------------------------------------------------------------------
module bgr_core #(
  parameter int unsigned RELAY_COUNT      = bgr_pkg::RELAY_COUNT_DEF,
  parameter int unsigned LONG_PRESS_TICKS = bgr_pkg::LONG_PRESS_TICKS_DEF,
  parameter int unsigned TICKS_PER_SECOND = bgr_pkg::TICKS_PER_SECOND_DEF,
  parameter int unsigned CLICK_GAP_TICKS  = bgr_pkg::CLICK_GAP_TICKS_DEF,
  parameter int unsigned KEY_MAP_ENTRIES  = bgr_pkg::KEY_MAP_ENTRIES_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               proc_i,
  input  var  bgr_pkg::in_word_t  word_i,
  output logic [4:0]              key_index_o,
  input  wire logic [7:0]         key_byte_i,
  output bgr_pkg::out_word_t      result_o
);

  localparam int unsigned RW = bgr_pkg::RELAY_W;
  localparam logic [RW-1:0] RELAY_MASK = RW'((2**RELAY_COUNT) - 1);
  // held/TPS as a multiply by a rounded-up reciprocal; exact for 8-bit held
  localparam int unsigned RECIP = (65536 + TICKS_PER_SECOND - 1) / TICKS_PER_SECOND;

  // state
  logic [RW-1:0] relays_q, relays_d;
  logic          led_en_q, led_en_d;
  logic          lock_q, lock_d;
  logic          led_q, led_d;
  logic          prev_q, prev_d;
  logic [7:0]    held_q, held_d;
  logic [7:0]    clicks_q, clicks_d;
  logic [2:0]    gap_q, gap_d;
  logic [4:0]    blim_q, blim_d;
  logic [4:0]    bsteps_q, bsteps_d;
  logic          bphase_q, bphase_d;
  logic          brun_q, brun_d;

  logic [1:0]    ev_kind;
  logic [7:0]    ev_count;
  logic [24:0]   long_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relays_q <= '0;
      led_en_q <= 1'b1;
      lock_q   <= 1'b0;
      led_q    <= 1'b0;
      prev_q   <= 1'b0;
      held_q   <= '0;
      clicks_q <= '0;
      gap_q    <= '0;
      blim_q   <= '0;
      bsteps_q <= '0;
      bphase_q <= 1'b0;
      brun_q   <= 1'b0;
    end else if (proc_i) begin
      relays_q <= relays_d;
      led_en_q <= led_en_d;
      lock_q   <= lock_d;
      led_q    <= led_d;
      prev_q   <= prev_d;
      held_q   <= held_d;
      clicks_q <= clicks_d;
      gap_q    <= gap_d;
      blim_q   <= blim_d;
      bsteps_q <= bsteps_d;
      bphase_q <= bphase_d;
      brun_q   <= brun_d;
    end
  end

  assign long_prod = {17'b0, held_q} * 25'(RECIP);

  // button edges, click burst and gap timer
  always_comb begin
    logic click_rel;
    logic long_rel;
    prev_d   = prev_q;
    held_d   = held_q;
    clicks_d = clicks_q;
    gap_d    = gap_q;
    ev_kind  = bgr_pkg::EV_NONE;
    ev_count = '0;
    click_rel = 1'b0;
    long_rel  = 1'b0;
    if (word_i.mode == bgr_pkg::MODE_TICK) begin
      if (word_i.button_pressed) begin
        if (!prev_q) begin
          held_d = 8'd1;
        end else if (held_q != 8'hff) begin
          held_d = held_q + 8'd1;
        end
      end else if (prev_q) begin
        if (held_q < 8'(LONG_PRESS_TICKS)) begin
          if (clicks_q != 8'hff) begin
            clicks_d = clicks_q + 8'd1;
          end
          click_rel = 1'b1;
        end else begin
          long_rel = 1'b1;
          ev_kind  = bgr_pkg::EV_LONG;
          ev_count = long_prod[23:16];
        end
        held_d = '0;
      end
      prev_d = word_i.button_pressed;

      if (click_rel) begin
        gap_d = 3'(CLICK_GAP_TICKS);
      end else if (gap_q != 3'd0) begin
        if (long_rel) begin
          // expiry held off one tick behind a long press
          if (gap_q > 3'd1) begin
            gap_d = gap_q - 3'd1;
          end
        end else begin
          gap_d = gap_q - 3'd1;
          if (gap_q == 3'd1) begin
            if (clicks_q != 8'd0) begin
              ev_kind  = bgr_pkg::EV_CLICK;
              ev_count = clicks_q;
            end
            clicks_d = '0;
          end
        end
      end
    end
  end

  assign key_index_o = ev_count[4:0];

  // relays, LED, blink and dispatch
  always_comb begin
    logic          in_range;
    logic [3:0]    nib;
    logic [2:0]    ridx;
    logic [RW-1:0] sel;
    relays_d = relays_q;
    led_en_d = led_en_q;
    lock_d   = lock_q;
    led_d    = led_q;
    blim_d   = blim_q;
    bsteps_d = bsteps_q;
    bphase_d = bphase_q;
    brun_d   = brun_q;
    result_o = '0;
    result_o.action_code = bgr_pkg::FN_NONE;
    in_range = (ev_count != 8'd0) && (ev_count <= 8'(KEY_MAP_ENTRIES));
    nib  = (ev_kind == bgr_pkg::EV_LONG) ? key_byte_i[7:4] : key_byte_i[3:0];
    ridx = 3'(nib - 4'd1);
    sel  = '0;

    if (word_i.mode == bgr_pkg::MODE_SOFT) begin
      sel = RW'(RW'(1) << word_i.socket_index);
      if (32'(word_i.socket_index) < RELAY_COUNT) begin
        case (word_i.socket_value)
          bgr_pkg::SOCK_OFF:    relays_d = relays_q & ~sel;
          bgr_pkg::SOCK_ON:     relays_d = relays_q | sel;
          bgr_pkg::SOCK_TOGGLE: relays_d = relays_q ^ sel;
          default: ;
        endcase
        if (word_i.socket_value != 2'd3) begin
          relays_d = relays_d & RELAY_MASK;
          led_d    = (relays_d != '0) && led_en_q;
        end
      end
    end else begin
      if (brun_q) begin
        if (bsteps_q >= blim_q) begin
          led_d  = 1'b0;
          brun_d = 1'b0;
        end else begin
          bphase_d = ~bphase_q;
          led_d    = ~bphase_q;
          bsteps_d = bsteps_q + 5'd1;
        end
      end

      if (ev_kind != bgr_pkg::EV_NONE && in_range) begin
        result_o.action_code = nib;
        if (nib == bgr_pkg::FN_LOCK) begin
          lock_d = ~lock_q;
        end else if (nib <= bgr_pkg::FN_FACTORY) begin
          if (lock_q) begin
            result_o.action_blocked = 1'b1;
          end else begin
            case (nib) inside
              bgr_pkg::FN_TOGGLE_ALL: begin
                relays_d = (relays_q != '0) ? '0 : RELAY_MASK;
                led_d    = (relays_d != '0) && led_en_q;
              end
              [bgr_pkg::FN_RELAY_FIRST:bgr_pkg::FN_RELAY_LAST]: begin
                if (32'(ridx) < RELAY_COUNT) begin
                  relays_d = (relays_q ^ RW'(RW'(1) << ridx)) & RELAY_MASK;
                  led_d    = (relays_d != '0) && led_en_q;
                end
              end
              bgr_pkg::FN_LED: begin
                led_en_d = ~led_en_q;
                led_d    = (relays_q != '0) && ~led_en_q;
              end
              bgr_pkg::FN_REBOOT: begin
                result_o.reboot_request = 1'b1;
              end
              bgr_pkg::FN_WIFI: begin
                blim_d   = bgr_pkg::BLINK_WIFI_LIMIT;
                bsteps_d = '0;
                bphase_d = 1'b0;
                brun_d   = 1'b1;
                result_o.wifi_setup_request = 1'b1;
              end
              bgr_pkg::FN_FACTORY: begin
                blim_d   = bgr_pkg::BLINK_FACTORY_LIMIT;
                bsteps_d = '0;
                bphase_d = 1'b0;
                brun_d   = 1'b1;
                result_o.factory_reset_request = 1'b1;
              end
              default: ;
            endcase
          end
        end
      end
    end

    result_o.relay_outputs = relays_d;
    result_o.led_on        = led_d;
    result_o.led_enabled   = led_en_d;
    result_o.child_lock_on = lock_d;
    result_o.event_kind    = ev_kind;
    result_o.event_count   = ev_count;
  end

endmodule
`default_nettype wire

>>> hdl/button_gesture_relay_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// button_gesture_relay_controller
// Multi-click / long-press button decoder driving relays, LED and requests.
//
//   channel  | handshake                | word
//   ---------+--------------------------+---------------------------
//   input    | in_valid_i / in_ready_o  | in_data_i  (in_word_t)
//   output   | out_valid_o / out_ready_i| out_data_o (out_word_t)
//   config   | cfg_we_i                 | cfg_index_i, cfg_data_i
//
// One word per cycle sustained while out_ready_i is high; a word passes
// the input register, then gesture/dispatch logic into the output register.
// All gesture and relay state sits in bgr_core and moves when a word passes
// from the input register to the output register.
// Reset: relays off, LED enabled, lock off, key map all ones.
// A stalled output holds its word; the input register keeps taking a word
// whenever the one ahead of it can move.
// ----------------------------------------------------------------------------
module button_gesture_relay_controller #(
  parameter int unsigned RELAY_COUNT      = bgr_pkg::RELAY_COUNT_DEF,
  parameter int unsigned LONG_PRESS_TICKS = bgr_pkg::LONG_PRESS_TICKS_DEF,
  parameter int unsigned TICKS_PER_SECOND = bgr_pkg::TICKS_PER_SECOND_DEF,
  parameter int unsigned CLICK_GAP_TICKS  = bgr_pkg::CLICK_GAP_TICKS_DEF,
  parameter int unsigned KEY_MAP_ENTRIES  = bgr_pkg::KEY_MAP_ENTRIES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  var  bgr_pkg::in_word_t              in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output bgr_pkg::out_word_t                  out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [bgr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bgr_pkg::KEY_REG_W-1:0]  cfg_data_i
);

  logic               s1_valid_q;
  bgr_pkg::in_word_t  s1_word_q;
  logic               out_valid_q;
  bgr_pkg::out_word_t out_word_q;
  logic               advance;
  logic               proc;
  logic               in_acc;
  logic [4:0]         key_index;
  logic [7:0]         key_byte;
  bgr_pkg::out_word_t result;

  assign advance    = !out_valid_q || out_ready_i;
  assign proc       = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (proc) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_word_q <= in_data_i;
    end
    if (proc) begin
      out_word_q <= result;
    end
  end

  bgr_keymap u_keymap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .key_index_i (key_index),
    .key_byte_o  (key_byte)
  );

  bgr_core #(
    .RELAY_COUNT      (RELAY_COUNT),
    .LONG_PRESS_TICKS (LONG_PRESS_TICKS),
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .CLICK_GAP_TICKS  (CLICK_GAP_TICKS),
    .KEY_MAP_ENTRIES  (KEY_MAP_ENTRIES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .proc_i      (proc),
    .word_i      (s1_word_q),
    .key_index_o (key_index),
    .key_byte_i  (key_byte),
    .result_o    (result)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

endmodule
`default_nettype wire
